### sv/otlt_pkg.sv
// ----------------------------------------------------------------------------
// otlt_pkg
// Shared types, constants and helpers for the object track table block.
// ----------------------------------------------------------------------------
`default_nettype none
package otlt_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int HeldW      = 5;
  localparam logic [15:0] EmptyDx    = 16'hFF00;
  localparam logic [15:0] StaleReset = 16'd500;

  typedef enum logic [0:0] {
    REQ_OBJECT = 1'b0,
    REQ_TICK   = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    LANE_NONE   = 2'd0,
    LANE_CENTRE = 2'd1,
    LANE_LEFT   = 2'd2,
    LANE_RIGHT  = 2'd3
  } lane_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_WRITE,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [15:0]        id;
    logic [15:0]        dx;
    logic signed [15:0] dy;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] ax;
    logic [7:0]         path;
    logic [1:0]         lane;
    logic [31:0]        stamp;
  } obj_t;

  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  waddr;
    obj_t             wdata;
  } mem_wr_t;

  function automatic obj_t blank_target();
    obj_t o;
    o    = '0;
    o.dx = EmptyDx;
    return o;
  endfunction

endpackage
`default_nettype wire

### sv/otlt_age_cmp.sv
// ----------------------------------------------------------------------------
// otlt_age_cmp
// Age check: true when (later - earlier), taken as an exact signed value,
// exceeds the limit.
// ----------------------------------------------------------------------------
`default_nettype none
module otlt_age_cmp
  import otlt_pkg::*;
(
  input  wire logic [31:0] later,
  input  wire logic [31:0] earlier,
  input  wire logic [15:0] limit,
  output logic             older
);

  logic signed [33:0] diff;

  assign diff  = $signed({2'b00, later}) - $signed({2'b00, earlier});
  assign older = diff > $signed({18'd0, limit});

endmodule
`default_nettype wire

### sv/otlt_track_mem.sv
// ----------------------------------------------------------------------------
// otlt_track_mem
// Track table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module otlt_track_mem
  import otlt_pkg::*;
(
  input  wire logic            clk,
  input  wire mem_wr_t         wr,
  input  wire logic [IdxW-1:0] raddr,
  output obj_t                 rdata
);

  obj_t mem_r [TableDepth];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_r[wr.waddr] <= wr.wdata;
    end
  end

  // address is the next scan index, so data lines up with the current one
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

### sv/object_track_table_lane_target_top.sv
// ----------------------------------------------------------------------------
// object_track_table_lane_target_top
// Track table keyed by object id with three lane targets.
//
// Input requests (in_*) carry either an object (tuser 0) or a tick (tuser 1).
// An object request scans the table for its id (one entry per cycle) and
// then writes. A tick checks the receive timeout, then walks the table
// once, dropping stale entries in order and updating the lane targets
// from the entries it keeps, followed by three results on out_* (tuser =
// lane slot, tlast on the third). in_tready is high only while the block
// is idle. A stalled receiver holds the current result and the block
// waits. Reset empties the table and lane targets and loads a 500 ms
// tolerance; cfg_we writes it.
// ----------------------------------------------------------------------------
`default_nettype none
module object_track_table_lane_target_top
  import otlt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [15:0]  cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // id, dx, dy, vx, vy, ax, path, lane, obj_time_ms, now_ms (low to high)
  input  wire logic [175:0] in_tdata,
  // req_type
  input  wire logic [0:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // id, dx, dy, vx, vy, ax, path, lane, time_ms, tracks_held (low to high)
  output logic [143:0]      out_tdata,
  // lane_slot
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  state_t          state_r, state_nxt;
  logic [15:0]     stale_r;
  logic [CntW-1:0] count_r, count_nxt;
  logic [CntW-1:0] idx_r, idx_nxt;
  logic [CntW-1:0] wptr_r, wptr_nxt;
  logic [IdxW-1:0] at_r, at_nxt;
  logic            found_r, found_nxt;
  logic [1:0]      slot_r, slot_nxt;
  obj_t            req_r, req_nxt;
  obj_t            tgt_r [3];
  obj_t            tgt_nxt [3];
  logic [31:0]     last_msg_r, last_msg_nxt;
  logic [31:0]     last_arr_r, last_arr_nxt;

  obj_t        in_obj, entry, cur_tgt;
  mem_wr_t     wr;
  logic [31:0] cmp_later, cmp_earlier;
  logic        older;
  logic        accept;
  logic [1:0]  lidx;

  assign in_obj.id    = in_tdata[15:0];
  assign in_obj.dx    = in_tdata[31:16];
  assign in_obj.dy    = in_tdata[47:32];
  assign in_obj.vx    = in_tdata[63:48];
  assign in_obj.vy    = in_tdata[79:64];
  assign in_obj.ax    = in_tdata[95:80];
  assign in_obj.path  = in_tdata[103:96];
  assign in_obj.lane  = in_tdata[105:104];
  assign in_obj.stamp = in_tdata[137:106];

  otlt_track_mem u_mem (
    .clk   (clk),
    .wr    (wr),
    .raddr (idx_nxt[IdxW-1:0]),
    .rdata (entry)
  );

  otlt_age_cmp u_cmp (
    .later   (cmp_later),
    .earlier (cmp_earlier),
    .limit   (stale_r),
    .older   (older)
  );

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign lidx      = entry.lane - 2'd1;
  assign cur_tgt   = tgt_r[lidx];

  // comparator shared between the receive timeout and the stale check
  always_comb begin
    if (state_r == S_IDLE) begin
      cmp_later   = in_tdata[169:138];
      cmp_earlier = last_arr_r;
    end else begin
      cmp_later   = last_msg_r;
      cmp_earlier = entry.stamp;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    wptr_nxt     = wptr_r;
    at_nxt       = at_r;
    found_nxt    = found_r;
    slot_nxt     = slot_r;
    req_nxt      = req_r;
    last_msg_nxt = last_msg_r;
    last_arr_nxt = last_arr_r;
    for (int k = 0; k < 3; k++) begin
      tgt_nxt[k] = tgt_r[k];
    end
    wr = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt  = '0;
          wptr_nxt = '0;
          if (in_tuser[0] == REQ_OBJECT) begin
            req_nxt      = in_obj;
            found_nxt    = 1'b0;
            last_arr_nxt = in_tdata[169:138];
            last_msg_nxt = in_obj.stamp;
            state_nxt    = S_FIND;
          end else begin
            if (older) begin
              count_nxt = '0;
              for (int k = 0; k < 3; k++) begin
                tgt_nxt[k] = blank_target();
              end
            end
            state_nxt = S_SCAN;
          end
        end
      end
      S_FIND: begin
        if (idx_r == count_r) begin
          state_nxt = S_WRITE;
        end else begin
          if (entry.id == req_r.id) begin
            found_nxt = 1'b1;
            at_nxt    = idx_r[IdxW-1:0];
          end
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_WRITE: begin
        wr.wdata = req_r;
        if (found_r) begin
          wr.we    = 1'b1;
          wr.waddr = at_r;
        end else if (count_r < CntW'(TableDepth)) begin
          wr.we     = 1'b1;
          wr.waddr  = count_r[IdxW-1:0];
          count_nxt = count_r + 1'b1;
        end
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (idx_r == count_r) begin
          count_nxt = wptr_r;
          slot_nxt  = 2'd0;
          state_nxt = S_EMIT;
        end else begin
          if (!older) begin
            // compact in place; write pointer never passes the read index
            wr.we    = 1'b1;
            wr.waddr = wptr_r[IdxW-1:0];
            wr.wdata = entry;
            wptr_nxt = wptr_r + 1'b1;
            if (entry.lane != LANE_NONE) begin
              if (entry.dx <= cur_tgt.dx || entry.id == cur_tgt.id) begin
                tgt_nxt[lidx] = entry;
              end else begin
                tgt_nxt[lidx] = blank_target();
              end
            end
          end
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (out_tready) begin
          if (slot_r == 2'd2) begin
            state_nxt = S_IDLE;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      stale_r    <= StaleReset;
      count_r    <= '0;
      idx_r      <= '0;
      wptr_r     <= '0;
      at_r       <= '0;
      found_r    <= 1'b0;
      slot_r     <= '0;
      last_msg_r <= '0;
      last_arr_r <= '0;
      for (int k = 0; k < 3; k++) begin
        tgt_r[k] <= blank_target();
      end
    end else begin
      state_r    <= state_nxt;
      if (cfg_we) begin
        stale_r <= cfg_wdata;
      end
      count_r    <= count_nxt;
      idx_r      <= idx_nxt;
      wptr_r     <= wptr_nxt;
      at_r       <= at_nxt;
      found_r    <= found_nxt;
      slot_r     <= slot_nxt;
      last_msg_r <= last_msg_nxt;
      last_arr_r <= last_arr_nxt;
      for (int k = 0; k < 3; k++) begin
        tgt_r[k] <= tgt_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

  obj_t out_obj;
  assign out_obj    = tgt_r[slot_r];
  assign out_tvalid = (state_r == S_EMIT);
  assign out_tuser  = slot_r;
  assign out_tlast  = (slot_r == 2'd2);
  assign out_tdata  = {1'b0, HeldW'(count_r), out_obj.stamp, out_obj.lane, out_obj.path,
                       out_obj.ax, out_obj.vy, out_obj.vx, out_obj.dy, out_obj.dx,
                       out_obj.id};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(TableDepth)) else $error("track count beyond table depth");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input taken while results pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready) else $error("ready right after a request");

  a_tick_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && idx_r == count_r) |=> (out_tvalid && out_tuser == 2'd0))
    else $error("tick walk did not lead to first result");

endmodule
`default_nettype wire
